// ===== hdl/z_buffer_depth_test_assert.svh =====
// Assertion macros shared by the depth buffer RTL.
// Expects clk and rst_n in the scope of the including module.
`ifndef Z_BUFFER_DEPTH_TEST_ASSERT_SVH
`define Z_BUFFER_DEPTH_TEST_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define ZB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("depth buffer assertion failed");

// Next-cycle implication, checked out of reset.
`define ZB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("depth buffer assertion failed");

`endif

// ===== hdl/zbdt_pkg.sv =====
// Shared widths, register codes and types of the depth buffer.
// No dependencies.
`timescale 1ns / 1ps

package zbdt_pkg;

  localparam int CFG_W   = 8;
  localparam int COORD_W = 11;
  localparam int Z_W     = 16;
  localparam int COLOR_W = 32;
  localparam int XY_W    = 7;
  localparam int IDX_W   = 1;

  localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;
  localparam logic [CFG_W-1:0] FRAME_RESET      = 8'd128;

  localparam logic ACT_CLEAR = 1'b1;

  typedef struct packed {
    logic busy;
    logic fin;
  } sweep_stat_t;

  typedef struct packed {
    logic           valid;
    logic [Z_W-1:0] depth;
  } entry_t;

endpackage

// ===== hdl/zbdt_ram.sv =====
// Single-port-write, single-port-read depth store with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module zbdt_ram #(
  parameter int AW = 14,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata_r
);

  logic [DW-1:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read-before-write on a collision; the caller forwards
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

// ===== hdl/zbdt_addr.sv =====
// Frame bounds check and linear store address of a fragment, registered.
// Depends on zbdt_pkg.
`timescale 1ns / 1ps

module zbdt_addr #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128,
  parameter int AW         = 14
) (
  input  logic                                 clk,
  input  logic                                 load,
  input  logic        [zbdt_pkg::CFG_W-1:0]    frame_width,
  input  logic        [zbdt_pkg::CFG_W-1:0]    frame_height,
  input  logic signed [zbdt_pkg::COORD_W-1:0]  pixel_x,
  input  logic signed [zbdt_pkg::COORD_W-1:0]  pixel_y,
  output logic                                 inb_r,
  output logic        [AW-1:0]                 addr_r
);

  import zbdt_pkg::*;

  localparam int WCAP   = (MAX_WIDTH > 255) ? 255 : MAX_WIDTH;
  localparam int HCAP   = (MAX_HEIGHT > 255) ? 255 : MAX_HEIGHT;
  localparam int PW_MIN = COORD_W - 1 + CFG_W + 1;
  localparam int PW     = (AW > PW_MIN) ? AW : PW_MIN;

  logic [CFG_W-1:0]   ew;
  logic [CFG_W-1:0]   eh;
  logic [COORD_W-2:0] xm;
  logic [COORD_W-2:0] ym;
  logic               in_x;
  logic               in_y;
  logic [PW-1:0]      idx;

  always_comb begin
    ew   = (frame_width > CFG_W'(WCAP)) ? CFG_W'(WCAP) : frame_width;
    eh   = (frame_height > CFG_W'(HCAP)) ? CFG_W'(HCAP) : frame_height;
    xm   = pixel_x[COORD_W-2:0];
    ym   = pixel_y[COORD_W-2:0];
    in_x = !pixel_x[COORD_W-1] && (xm < (COORD_W-1)'(ew));
    in_y = !pixel_y[COORD_W-1] && (ym < (COORD_W-1)'(eh));
    idx  = PW'(ym) * PW'(ew) + PW'(xm);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      inb_r  <= in_x && in_y;
      addr_r <= idx[AW-1:0];
    end
  end

endmodule

// ===== hdl/zbdt_sweep.sv =====
// Clearing sequencer: walks the whole depth store once after reset and on request.
// Depends on zbdt_pkg.
`timescale 1ns / 1ps

module zbdt_sweep #(
  parameter int AW    = 14,
  parameter int DEPTH = 16384
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output zbdt_pkg::sweep_stat_t stat,
  output logic [AW-1:0]         addr
);

  import zbdt_pkg::*;

  localparam logic [1:0] SW_INIT  = 2'd0;
  localparam logic [1:0] SW_IDLE  = 2'd1;
  localparam logic [1:0] SW_CLEAR = 2'd2;

  localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

  logic [1:0]    state_r;
  logic [1:0]    state_nxt;
  logic [AW-1:0] cnt_r;
  logic [AW-1:0] cnt_nxt;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    stat.busy = 1'b0;
    stat.fin  = 1'b0;
    case (state_r)
      SW_INIT, SW_CLEAR: begin
        stat.busy = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          state_nxt = SW_IDLE;
          cnt_nxt   = '0;
          stat.fin  = (state_r == SW_CLEAR);
        end
      end
      SW_IDLE: begin
        if (start) begin
          state_nxt = SW_CLEAR;
        end
      end
      default: begin
        state_nxt = SW_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  assign addr = cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SW_INIT;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// ===== hdl/z_buffer_depth_test.sv =====
// Depth buffer top level: fragment pipeline, depth store, forwarding and clear control.
// Depends on zbdt_pkg, zbdt_ram, zbdt_addr, zbdt_sweep and z_buffer_depth_test_assert.svh.
//
//   Channel   Direction   Handshake               Beat
//   in_*      input       in_valid / in_ready     action, x, y, depth, color
//   out_*     output      out_valid / out_ready   write enable, x, y, color, clear done
//   cfg_*     input       cfg_we                  frame width / height register write
//
// One fragment per cycle when nothing stalls; each moves through address, store read, test.
// A clear beat holds the input until the sweep of all MAX_WIDTH*MAX_HEIGHT entries ends.
// After reset the same sweep runs (16384 entries at defaults) with in_ready low.
// A stalled output holds the whole pipeline; in_ready follows out_ready combinationally.
`timescale 1ns / 1ps

module z_buffer_depth_test #(
  parameter int MAX_WIDTH  = 128,
  parameter int MAX_HEIGHT = 128
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // fragment input
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_action,
  input  logic signed [zbdt_pkg::COORD_W-1:0] in_pixel_x,
  input  logic signed [zbdt_pkg::COORD_W-1:0] in_pixel_y,
  input  logic signed [zbdt_pkg::Z_W-1:0]     in_depth,
  input  logic        [zbdt_pkg::COLOR_W-1:0] in_color,
  // pixel write output
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_write_enable,
  output logic        [zbdt_pkg::XY_W-1:0]    out_x,
  output logic        [zbdt_pkg::XY_W-1:0]    out_y,
  output logic        [zbdt_pkg::COLOR_W-1:0] out_color,
  output logic                                out_clear_done,
  // configuration
  input  logic                                cfg_we,
  input  logic        [zbdt_pkg::IDX_W-1:0]   cfg_index,
  input  logic        [zbdt_pkg::CFG_W-1:0]   cfg_wdata
);

  import zbdt_pkg::*;

  `include "z_buffer_depth_test_assert.svh"

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = $bits(entry_t);

  // configuration registers
  logic [CFG_W-1:0] frame_width_r;
  logic [CFG_W-1:0] frame_height_r;

  // pipeline control
  logic adv;
  logic accept;
  logic clr_pend;
  logic swept_r;
  logic clr_stall;

  // address stage
  logic                    s1_v_r;
  logic                    s1_clr_r;
  logic signed [Z_W-1:0]   s1_z_r;
  logic [COLOR_W-1:0]      s1_color_r;
  logic [XY_W-1:0]         s1_x_r;
  logic [XY_W-1:0]         s1_y_r;
  logic                    s1_inb;
  logic [AW-1:0]           s1_addr;

  // test stage
  logic                    s2_v_r;
  logic                    s2_clr_r;
  logic                    s2_inb_r;
  logic [AW-1:0]           s2_addr_r;
  logic signed [Z_W-1:0]   s2_z_r;
  logic [COLOR_W-1:0]      s2_color_r;
  logic [XY_W-1:0]         s2_x_r;
  logic [XY_W-1:0]         s2_y_r;
  logic                    s2_pass;
  logic                    s2_we;

  // forwarding of the write that shared an edge with the stage-2 read
  logic                    fwd_v_r;
  logic [AW-1:0]           fwd_addr_r;
  logic [Z_W-1:0]          fwd_z_r;
  entry_t                  rd_ent;

  // store and sweep
  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [DW-1:0]           ram_wdata;
  logic [DW-1:0]           ram_rdata;
  sweep_stat_t             stat;
  logic [AW-1:0]           sweep_addr;
  logic                    sweep_start;

  // output register
  logic                    out_valid_r;
  logic                    out_we_r;
  logic [XY_W-1:0]         out_x_r;
  logic [XY_W-1:0]         out_y_r;
  logic [COLOR_W-1:0]      out_color_r;
  logic                    out_clr_r;

  // Register writes; an unknown index drops the write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_RESET;
      frame_height_r <= FRAME_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Hold everything while the output is full, or while a clear waits at the test
  // stage for its sweep to finish.
  assign clr_stall = s2_v_r && s2_clr_r && !swept_r;
  assign adv       = (!out_valid_r || out_ready) && !clr_stall;

  // Nothing enters behind a clear until it has left the test stage.
  assign clr_pend  = (s1_v_r && s1_clr_r) || (s2_v_r && s2_clr_r);
  assign in_ready  = adv && !stat.busy && !clr_pend;
  assign accept    = in_valid && in_ready;

  // Address stage: bounds and linear index land in zbdt_addr's registers.
  zbdt_addr #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT),
    .AW         (AW)
  ) u_addr (
    .clk          (clk),
    .load         (adv),
    .frame_width  (frame_width_r),
    .frame_height (frame_height_r),
    .pixel_x      (in_pixel_x),
    .pixel_y      (in_pixel_y),
    .inb_r        (s1_inb),
    .addr_r       (s1_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_clr_r   <= (in_action == ACT_CLEAR);
      s1_z_r     <= in_depth;
      s1_color_r <= in_color;
      s1_x_r     <= in_pixel_x[XY_W-1:0];
      s1_y_r     <= in_pixel_y[XY_W-1:0];
      s2_clr_r   <= s1_clr_r;
      s2_inb_r   <= s1_inb;
      s2_addr_r  <= s1_addr;
      s2_z_r     <= s1_z_r;
      s2_color_r <= s1_color_r;
      s2_x_r     <= s1_x_r;
      s2_y_r     <= s1_y_r;
    end
  end

  // Depth store: read as an item moves into the test stage, write back when it passes.
  zbdt_ram #(
    .AW (AW),
    .DW (DW)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (adv),
    .raddr   (s1_addr),
    .rdata_r (ram_rdata)
  );

  // Test stage: take the forwarded entry when the previous beat wrote the same address
  // on the edge that read this one.
  always_comb begin
    if (fwd_v_r && (fwd_addr_r == s2_addr_r)) begin
      rd_ent.valid = 1'b1;
      rd_ent.depth = fwd_z_r;
    end else begin
      rd_ent = entry_t'(ram_rdata);
    end
    s2_pass = s2_v_r && !s2_clr_r && s2_inb_r &&
              (!rd_ent.valid || (s2_z_r < $signed(rd_ent.depth)));
    s2_we   = s2_pass && adv;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_v_r <= 1'b0;
    end else if (adv) begin
      fwd_v_r <= s2_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd_addr_r <= s2_addr_r;
      fwd_z_r    <= s2_z_r;
    end
  end

  // Clear sequencing: start the sweep once the clear sits in the test stage, so every
  // earlier write is already in the store.
  assign sweep_start = clr_stall && !stat.busy;

  zbdt_sweep #(
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_sweep (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sweep_start),
    .stat  (stat),
    .addr  (sweep_addr)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      swept_r <= 1'b0;
    end else if (stat.fin) begin
      swept_r <= 1'b1;
    end else if (adv && s2_v_r && s2_clr_r) begin
      swept_r <= 1'b0;
    end
  end

  // The sweep owns the write port; the pipeline never writes while it runs.
  always_comb begin
    if (stat.busy) begin
      ram_we    = 1'b1;
      ram_waddr = sweep_addr;
      ram_wdata = '0;
    end else begin
      ram_we    = s2_we;
      ram_waddr = s2_addr_r;
      ram_wdata = DW'({1'b1, s2_z_r});
    end
  end

  // Output register: advance with the pipeline, drop a taken beat while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s2_v_r;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_we_r    <= s2_pass;
      out_x_r     <= s2_pass ? s2_x_r : '0;
      out_y_r     <= s2_pass ? s2_y_r : '0;
      out_color_r <= s2_pass ? s2_color_r : '0;
      out_clr_r   <= s2_clr_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_write_enable = out_we_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_color        = out_color_r;
  assign out_clear_done   = out_clr_r;

  `ZB_ASSERT_IMP(a_no_accept_in_sweep, stat.busy, !in_ready)
  `ZB_ASSERT_IMP(a_sweep_owns_port, stat.busy, !s2_we)
  `ZB_ASSERT_NXT(a_clear_blocks_input, in_valid && in_ready && (in_action == ACT_CLEAR), !in_ready)
  `ZB_ASSERT_IMP(a_clear_no_write, out_valid && out_clear_done, !out_write_enable)

endmodule

// ===== tb/testbench.sv =====
// Self-checking bench for the depth buffer: fragment, clear and frame-size traffic.
// Depends on zbdt_pkg and the z_buffer_depth_test RTL; nothing else is read.
`timescale 1ns / 1ps

module testbench;
  import zbdt_pkg::*;

  // Geometry of the block under test.
  localparam int FRAME_MAX   = 128;
  localparam int STORE_DEPTH = FRAME_MAX * FRAME_MAX;
  localparam logic ACT_TEST  = ~ACT_CLEAR;

  // Run shape. Each clear sweeps the whole store (16384 entries), and so does reset.
  // The slowest correct run is about 13 sweeps plus 1600 beats under stalls and one
  // long hold-off; the cycle limit sits well above that.
  localparam int PHASE_BEATS    = 175;
  localparam int NUM_PHASES     = 9;
  localparam int CLEAR_BUDGET   = 10;
  localparam int PRESSURE_PHASE = 6;
  localparam int HOLD_CYCLES    = 400;
  localparam int TAIL_CYCLES    = 12;
  localparam int CYCLE_LIMIT    = 1_500_000;

  // Frame sizes per phase: saturating, zero and one-pixel frames among them.
  // The last phase picks a small random frame.
  localparam int PHASE_W [NUM_PHASES] = '{8, 1, 255, 0, 5, 128, 3, 16, 0};
  localparam int PHASE_H [NUM_PHASES] = '{8, 1, 255, 7, 0, 1, 17, 16, 0};

  // Idle modes, indexed by phase modulo 4: none, sender, receiver, both lightly.
  localparam int SEND_IDLE  [4] = '{0, 66, 0, 10};
  localparam int RECV_STALL [4] = '{0, 0, 66, 10};

  typedef struct {
    logic                      action;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [Z_W-1:0]     depth;
    logic        [COLOR_W-1:0] color;
  } fragment_t;

  typedef struct {
    logic               write_en;
    logic [XY_W-1:0]    x;
    logic [XY_W-1:0]    y;
    logic [COLOR_W-1:0] color;
    logic               clear_done;
  } pixel_write_t;

  // Mirror of the depth store plus the queue of pixel writes still owed by the block.
  class depth_tracker;
    bit                    valid_map [STORE_DEPTH];
    logic signed [Z_W-1:0] depth_mem [STORE_DEPTH];
    int                    width_reg;
    int                    height_reg;
    pixel_write_t          pending_writes [$];
    int                    errors;
    int                    printed;
    int                    n_beats;
    int                    n_checked;
    int                    n_writes;
    int                    n_rejects;
    int                    n_clears;
    int                    n_compares;

    function new();
      width_reg  = FRAME_RESET;
      height_reg = FRAME_RESET;
      foreach (valid_map[i]) valid_map[i] = 1'b0;
    endfunction

    function void set_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_FRAME_WIDTH) width_reg = val;
      else if (idx == REG_FRAME_HEIGHT) height_reg = val;
    endfunction

    function int eff_width();
      return (width_reg > FRAME_MAX) ? FRAME_MAX : width_reg;
    endfunction

    function int eff_height();
      return (height_reg > FRAME_MAX) ? FRAME_MAX : height_reg;
    endfunction

    function pixel_write_t predict_pixel_write(fragment_t f);
      pixel_write_t r;
      int           ew;
      int           eh;
      int           px;
      int           py;
      int           slot;
      r.write_en   = 1'b0;
      r.x          = '0;
      r.y          = '0;
      r.color      = '0;
      r.clear_done = 1'b0;
      if (f.action == ACT_CLEAR) begin
        foreach (valid_map[i]) valid_map[i] = 1'b0;
        r.clear_done = 1'b1;
        n_clears++;
        return r;
      end
      ew = eff_width();
      eh = eff_height();
      px = f.x;
      py = f.y;
      if (px < 0 || py < 0 || px >= ew || py >= eh) begin
        n_rejects++;
        return r;
      end
      slot = py * ew + px;
      if (valid_map[slot]) begin
        n_compares++;
        // strictly closer wins; a tie keeps the stored depth
        if (!(f.depth < depth_mem[slot])) begin
          n_rejects++;
          return r;
        end
      end
      valid_map[slot] = 1'b1;
      depth_mem[slot] = f.depth;
      r.write_en = 1'b1;
      r.x        = XY_W'(px);
      r.y        = XY_W'(py);
      r.color    = f.color;
      n_writes++;
      return r;
    endfunction

    function void note_fragment(fragment_t f);
      pending_writes.push_back(predict_pixel_write(f));
      n_beats++;
    endfunction

    task report_mismatch(string msg);
      errors++;
      if (printed < 40) begin
        printed++;
        $display("[%0t] mismatch on result %0d: %s", $time, n_checked, msg);
      end
    endtask

    task check_write(pixel_write_t got);
      pixel_write_t want;
      if (pending_writes.size() == 0) begin
        report_mismatch("result beat with no fragment outstanding");
        return;
      end
      want = pending_writes.pop_front();
      if (got.write_en !== want.write_en)
        report_mismatch($sformatf("write_enable %b, want %b", got.write_en, want.write_en));
      if (got.x !== want.x)
        report_mismatch($sformatf("out_x %0d, want %0d", got.x, want.x));
      if (got.y !== want.y)
        report_mismatch($sformatf("out_y %0d, want %0d", got.y, want.y));
      if (got.color !== want.color)
        report_mismatch($sformatf("out_color %h, want %h", got.color, want.color));
      if (got.clear_done !== want.clear_done)
        report_mismatch($sformatf("clear_done %b, want %b", got.clear_done, want.clear_done));
      n_checked++;
    endtask
  endclass

  logic                      clk = 1'b0;
  logic                      rst_n;
  logic                      in_valid;
  logic                      in_ready;
  logic                      in_action;
  logic signed [COORD_W-1:0] in_pixel_x;
  logic signed [COORD_W-1:0] in_pixel_y;
  logic signed [Z_W-1:0]     in_depth;
  logic        [COLOR_W-1:0] in_color;
  logic                      out_valid;
  logic                      out_ready;
  logic                      out_write_enable;
  logic        [XY_W-1:0]    out_x;
  logic        [XY_W-1:0]    out_y;
  logic        [COLOR_W-1:0] out_color;
  logic                      out_clear_done;
  logic                      cfg_we;
  logic        [IDX_W-1:0]   cfg_index;
  logic        [CFG_W-1:0]   cfg_wdata;

  depth_tracker book;
  int           sender_idle_pct = 0;
  int           recv_stall_pct  = 0;
  bit           hold_request    = 1'b0;
  int           clears_left     = CLEAR_BUDGET;
  fragment_t    recent [$];

  z_buffer_depth_test #(
    .MAX_WIDTH (FRAME_MAX),
    .MAX_HEIGHT(FRAME_MAX)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_pixel_x      (in_pixel_x),
    .in_pixel_y      (in_pixel_y),
    .in_depth        (in_depth),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_write_enable(out_write_enable),
    .out_x           (out_x),
    .out_y           (out_y),
    .out_color       (out_color),
    .out_clear_done  (out_clear_done),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic fragment_t frag_of(logic act, int x, int y, int z, logic [31:0] c);
    fragment_t f;
    f.action = act;
    f.x      = COORD_W'(x);
    f.y      = COORD_W'(y);
    f.depth  = Z_W'(z);
    f.color  = c;
    return f;
  endfunction

  // Coordinate on or just past a frame border, or at the ends of the 11-bit range.
  function automatic logic signed [COORD_W-1:0] edge_coord(int span);
    int pick [6];
    pick = '{-1, span, span + 1, FRAME_MAX, -(1 << (COORD_W - 1)), (1 << (COORD_W - 1)) - 1};
    return COORD_W'(pick[$urandom_range(5)]);
  endfunction

  // Mostly in-frame fragments so entries get hit again; revisit recent pixels with
  // equal or neighboring depths to exercise ties; sprinkle borders, full-range noise
  // and the odd clear.
  function automatic fragment_t random_fragment();
    fragment_t f;
    int        ew;
    int        eh;
    int        roll;
    int        k;
    int        d;
    ew       = book.eff_width();
    eh       = book.eff_height();
    f.action = ACT_TEST;
    f.color  = $urandom();
    f.depth  = Z_W'($urandom());
    roll     = $urandom_range(99);
    if (roll < 70) begin
      f.x = COORD_W'($urandom_range(ew > 0 ? ew - 1 : 3));
      f.y = COORD_W'($urandom_range(eh > 0 ? eh - 1 : 3));
    end else if (roll < 85) begin
      f.x = edge_coord(ew);
      f.y = ($urandom_range(1) == 0) ? edge_coord(eh) : COORD_W'($urandom_range(3));
    end else begin
      f.x = COORD_W'($urandom());
      f.y = COORD_W'($urandom());
    end
    roll = $urandom_range(99);
    if (roll < 25 && recent.size() > 0) begin
      k   = $urandom_range(recent.size() - 1);
      f.x = recent[k].x;
      f.y = recent[k].y;
      d   = recent[k].depth;
      d   = d + int'($urandom_range(2)) - 1;
      f.depth = Z_W'(d);
    end else if (roll < 31) begin
      f.depth = ($urandom_range(1) == 0) ? Z_W'(-32768) : Z_W'(32767);
    end
    recent.push_back(f);
    if (recent.size() > 8) void'(recent.pop_front());
    if (clears_left > 0 && $urandom_range(149) == 0) begin
      f.action = ACT_CLEAR;
      clears_left--;
    end
    return f;
  endfunction

  // Offer one beat after a random idle gap; hold it until accepted, then predict.
  task automatic send_beat(input fragment_t f);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_action  <= f.action;
    in_pixel_x <= f.x;
    in_pixel_y <= f.y;
    in_depth   <= f.depth;
    in_color   <= f.color;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    book.note_fragment(f);
  endtask

  // Write both frame registers on back-to-back edges.
  task automatic write_frame(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= REG_FRAME_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= REG_FRAME_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    book.set_reg(REG_FRAME_WIDTH, w);
    book.set_reg(REG_FRAME_HEIGHT, h);
  endtask

  // Drop valid and wait until every owed result has come back.
  task automatic drain();
    in_valid <= 1'b0;
    while (book.pending_writes.size() != 0) @(posedge clk);
  endtask

  // Result side: check each accepted beat, then pick next cycle's ready.
  // A hold-off request keeps ready low for a counted stretch so the pipe backs up.
  initial begin
    pixel_write_t got;
    int           hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.write_en   = out_write_enable;
        got.x          = out_x;
        got.y          = out_y;
        got.color      = out_color;
        got.clear_done = out_clear_done;
        book.check_write(got);
      end
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: a hung handshake ends the run here.
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results still owed", cycles,
             book.pending_writes.size());
    $display("** z_buffer_depth_test: FAILED **");
    $finish;
  end

  initial begin
    int ph;
    int b;
    int mode;
    book = new();

    // Known values on every input from time zero, with reset held at first.
    rst_n      <= 1'b0;
    in_valid   <= 1'b0;
    in_action  <= ACT_TEST;
    in_pixel_x <= '0;
    in_pixel_y <= '0;
    in_depth   <= '0;
    in_color   <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= REG_FRAME_WIDTH;
    cfg_wdata  <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed beats at the reset frame of 128 x 128. The block sweeps its store
    // after reset; the first beat simply waits for in_ready.
    // Clear with junk in the ignored fields.
    send_beat(frag_of(ACT_CLEAR, 5, -7, 16'h1234, 32'hDEADBEEF));
    // Empty entry passes; same depth again is a tie and fails; closer passes.
    send_beat(frag_of(ACT_TEST, 0, 0, 0, 32'hFFFFFFFF));
    send_beat(frag_of(ACT_TEST, 0, 0, 0, 32'h0F0F0F0F));
    send_beat(frag_of(ACT_TEST, 0, 0, -1, 32'h12345678));
    // Lowest depth on an empty entry passes, but not over a stored lowest depth.
    send_beat(frag_of(ACT_TEST, 1, 0, -32768, 32'h00000000));
    send_beat(frag_of(ACT_TEST, 1, 0, -32768, 32'hFFFFFFFF));
    // Far corner with the farthest depth, a tie, then one step closer.
    send_beat(frag_of(ACT_TEST, 127, 127, 32767, 32'hA5A5A5A5));
    send_beat(frag_of(ACT_TEST, 127, 127, 32767, 32'h5A5A5A5A));
    send_beat(frag_of(ACT_TEST, 127, 127, 32766, 32'hC3C3C3C3));
    // Off-screen on every side and at the coordinate range ends; then in-frame edge pixels.
    send_beat(frag_of(ACT_TEST, 128, 0, -100, 32'h11111111));
    send_beat(frag_of(ACT_TEST, 0, 128, -100, 32'h22222222));
    send_beat(frag_of(ACT_TEST, -1, 0, -100, 32'h33333333));
    send_beat(frag_of(ACT_TEST, 0, -1, -100, 32'h44444444));
    send_beat(frag_of(ACT_TEST, -1024, -1024, -100, 32'h55555555));
    send_beat(frag_of(ACT_TEST, 1023, 1023, -100, 32'h66666666));
    send_beat(frag_of(ACT_TEST, 127, 0, 5, 32'h77777777));
    send_beat(frag_of(ACT_TEST, 0, 127, -5, 32'h88888888));
    // After a clear, even the farthest depth lands on the old pixels.
    send_beat(frag_of(ACT_CLEAR, 0, 0, 0, 32'h00000000));
    send_beat(frag_of(ACT_TEST, 0, 0, 32767, 32'h99999999));
    send_beat(frag_of(ACT_TEST, 1, 0, 32767, 32'hAAAAAAAA));
    send_beat(frag_of(ACT_TEST, 127, 127, 32767, 32'hBBBBBBBB));
    drain();

    // Random phases. Frame changes happen only with the pipe empty and never clear
    // the store, so old entries get re-addressed under the new width.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == NUM_PHASES - 1)
        write_frame(CFG_W'($urandom_range(24, 1)), CFG_W'($urandom_range(24, 1)));
      else
        write_frame(CFG_W'(PHASE_W[ph]), CFG_W'(PHASE_H[ph]));
      mode            = ph % 4;
      sender_idle_pct = SEND_IDLE[mode];
      recv_stall_pct  = RECV_STALL[mode];
      // Back the pipe up: the receiver holds off while beats keep coming.
      if (ph == PRESSURE_PHASE) hold_request = 1'b1;
      for (b = 0; b < PHASE_BEATS; b++) send_beat(random_fragment());
      drain();
    end

    // Let any stray result surface before the verdict.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Ran %0d beats over %0d frame settings: %0d pixel writes, %0d rejects, %0d clears.",
             book.n_beats, NUM_PHASES + 1, book.n_writes, book.n_rejects, book.n_clears);
    $display("%0d fragments were tested against a filled entry; %0d mismatches counted.",
             book.n_compares, book.errors);
    if (book.errors == 0 && book.pending_writes.size() == 0)
      $display("** z_buffer_depth_test: PASSED **");
    else
      $display("** z_buffer_depth_test: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/zbdt_pkg.sv
hdl/zbdt_ram.sv
hdl/zbdt_addr.sv
hdl/zbdt_sweep.sv
hdl/z_buffer_depth_test.sv
tb/testbench.sv
